[rtl/wcrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_pkg
// Shared constants and types of the windowed count regression slope unit.
// ----------------------------------------------------------------------------
package wcrs_pkg;

   // window and region geometry
   localparam int WINDOW_BASES = 10000;
   localparam int MEGABASE     = 1000000;
   localparam int POS_W        = 28;
   localparam int REGION_W     = 9;
   localparam logic [REGION_W-1:0] REGION_RESET = REGION_W'(250);
   localparam int WIN_PER_MB   = MEGABASE / WINDOW_BASES;
   localparam int NWIN_W       = $clog2(((2**REGION_W) - 1) * WIN_PER_MB + 1);
   localparam int WIN_W        = $clog2(((2**POS_W) - 1) / WINDOW_BASES + 1);

   // division by the window size as a multiply by a rounded-up reciprocal
   localparam int RECIP_SHIFT = POS_W + $clog2(WINDOW_BASES);
   localparam int RECIP_W     = POS_W + 1;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << RECIP_SHIFT) + WINDOW_BASES - 1) / WINDOW_BASES;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int PROD_W = POS_W + RECIP_W;

   // counters and sums
   localparam int CNT_W  = 14;
   localparam int SUM_W  = 32;
   localparam int SQ_W   = 48;
   localparam int USED_W = 16;
   localparam int SLOPE_W = 48;

   // one queued item, already classified
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [WIN_W-1:0] win;
      logic             ctrl;
      logic             last;
      logic             in_region;
   } entry_type;

endpackage

[rtl/wcrs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_queue
// Four-entry item queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module wcrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wcrs_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output wcrs_pkg::entry_type head
);

   wcrs_pkg::entry_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   // status
   assign full       = (fill_ff == 3'd4);
   assign head_valid = (fill_ff != 3'd0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   // pointer update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, do_push};
      rd_ptr_in = rd_ptr_ff + {1'b0, do_pop};
      fill_in   = fill_ff + {2'b00, do_push} - {2'b00, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/wcrs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_front
// Accepts items, finds their window and tags whether it lies in the region.
// ----------------------------------------------------------------------------
module wcrs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wcrs_pkg::POS_W-1:0]        req_position,
   input  logic                              req_source,
   input  logic                              req_last,
   input  logic                              csr_wr_en,
   input  logic [wcrs_pkg::REGION_W-1:0]     csr_wr_data,
   output logic                              push,
   output wcrs_pkg::entry_type               push_entry,
   input  logic                              full
);

   logic [wcrs_pkg::REGION_W-1:0] region_ff;
   logic [wcrs_pkg::NWIN_W-1:0]   nwin;
   logic                          stage_valid_ff, stage_valid_in;
   logic [wcrs_pkg::PROD_W-1:0]   prod_ff;
   logic [wcrs_pkg::POS_W-1:0]    pos_ff;
   logic                          ctrl_ff, last_ff;
   logic                          accept;
   logic [wcrs_pkg::WIN_W-1:0]    win;

   // region register
   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= wcrs_pkg::REGION_RESET;
      end else if (csr_wr_en) begin
         region_ff <= csr_wr_data;
      end
   end

   assign nwin = wcrs_pkg::NWIN_W'(region_ff * wcrs_pkg::NWIN_W'(wcrs_pkg::WIN_PER_MB));

   // input handshake
   assign req_stall      = stage_valid_ff & full;
   assign accept         = req_valid & ~req_stall;
   assign stage_valid_in = accept | (stage_valid_ff & full);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // reciprocal multiply for the window index
   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= wcrs_pkg::PROD_W'(req_position) * wcrs_pkg::PROD_W'(wcrs_pkg::RECIP);
         pos_ff  <= req_position;
         ctrl_ff <= req_source;
         last_ff <= req_last;
      end
   end

   // classify and push
   assign win  = prod_ff[wcrs_pkg::RECIP_SHIFT +: wcrs_pkg::WIN_W];
   assign push = stage_valid_ff;

   always_comb begin
      push_entry.pos       = pos_ff;
      push_entry.win       = win;
      push_entry.ctrl      = ctrl_ff;
      push_entry.last      = last_ff;
      push_entry.in_region = (wcrs_pkg::NWIN_W'(win) < nwin);
   end

endmodule

[rtl/wcrs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcrs_back
// Counts distinct positions per window, accumulates the regression sums and
// works out the least-squares slope on the last item.
// ----------------------------------------------------------------------------
module wcrs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  wcrs_pkg::entry_type               head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [wcrs_pkg::SLOPE_W-1:0] rsp_slope_q16,
   output logic [wcrs_pkg::USED_W-1:0]       rsp_windows_used,
   output logic                              rsp_degenerate
);

   typedef enum logic [8:0] {
      ST_ITEM   = 9'b000000001,
      ST_CLOSE0 = 9'b000000010,
      ST_CLOSE1 = 9'b000000100,
      ST_CLOSE2 = 9'b000001000,
      ST_PROD   = 9'b000010000,
      ST_DIFF   = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_FIN    = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   localparam logic [wcrs_pkg::CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [wcrs_pkg::USED_W-1:0] USED_MAX = '1;
   localparam logic [wcrs_pkg::SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [wcrs_pkg::SQ_W-1:0]   SQ_MAX   = '1;
   localparam int HALF_W = wcrs_pkg::SQ_W / 2;
   localparam int DIV_STEPS = 64 + 16;
   localparam logic [6:0] DIV_LAST = 7'(DIV_STEPS - 1);
   localparam logic [48:0] POS_LIM = 49'((64'd1 << 47) - 64'd1);
   localparam logic [48:0] NEG_LIM = 49'(64'd1 << 47);

   state_type state_ff, state_in;
   logic final_ff, final_in;
   logic [wcrs_pkg::WIN_W-1:0]  open_ff, open_in;
   logic [wcrs_pkg::CNT_W-1:0]  scnt_ff, scnt_in, ccnt_ff, ccnt_in;
   logic [wcrs_pkg::POS_W-1:0]  slast_ff, slast_in, clast_ff, clast_in;
   logic [wcrs_pkg::SUM_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [wcrs_pkg::SQ_W-1:0]   sxx_ff, sxx_in, sxy_ff, sxy_in;
   logic [wcrs_pkg::USED_W-1:0] used_ff, used_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic [63:0] den_a_ff, den_a_in, den_b_ff, den_b_in;
   logic [63:0] den_ff, den_in, dvd_ff, dvd_in, rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic        ovf_ff, ovf_in, neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic signed [wcrs_pkg::SLOPE_W-1:0] res_slope_ff, res_slope_in;
   logic        res_degen_ff, res_degen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [wcrs_pkg::SLOPE_W-1:0] out_slope_ff, out_slope_in;
   logic [wcrs_pkg::USED_W-1:0] out_used_ff, out_used_in;
   logic        out_degen_ff, out_degen_in;

   logic        count_it, both_nz, out_free;
   logic [64:0] rem_sh, rem_diff;
   logic [48:0] sq_sum, m49, mag;
   logic [32:0] sx_sum, sy_sum;
   logic [64:0] rnd_cmp;
   logic        rnd, big;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign count_it = head.in_region & (head.win >= open_ff);
   assign both_nz  = (scnt_ff != '0) & (ccnt_ff != '0);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CLOSE0: begin
            mul_a = 32'(ccnt_ff);
            mul_b = 32'(ccnt_ff);
         end
         ST_CLOSE1: begin
            mul_a = 32'(ccnt_ff);
            mul_b = 32'(scnt_ff);
         end
         ST_PROD: begin
            case (step_ff)
               3'd0: begin mul_a = 32'(used_ff); mul_b = 32'(sxy_ff[HALF_W-1:0]); end
               3'd1: begin mul_a = 32'(used_ff); mul_b = 32'(sxy_ff[47:HALF_W]); end
               3'd2: begin mul_a = sx_ff; mul_b = sy_ff; end
               3'd3: begin mul_a = 32'(used_ff); mul_b = 32'(sxx_ff[HALF_W-1:0]); end
               3'd4: begin mul_a = 32'(used_ff); mul_b = 32'(sxx_ff[47:HALF_W]); end
               3'd5: begin mul_a = sx_ff; mul_b = sx_ff; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // divider step and rounding
   assign rem_sh   = {rem_ff, dvd_ff[63]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign rnd_cmp  = {rem_ff, 1'b0};
   assign rnd      = (rnd_cmp >= {1'b0, den_ff});
   assign big      = ovf_ff | q_ff[47];
   assign m49      = {1'b0, q_ff} + 49'(rnd);

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      final_in     = final_ff;
      open_in      = open_ff;
      scnt_in      = scnt_ff;
      ccnt_in      = ccnt_ff;
      slast_in     = slast_ff;
      clast_in     = clast_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      used_in      = used_ff;
      step_in      = step_ff;
      num_a_in     = num_a_ff;
      num_b_in     = num_b_ff;
      den_a_in     = den_a_ff;
      den_b_in     = den_b_ff;
      den_in       = den_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      res_slope_in = res_slope_ff;
      res_degen_in = res_degen_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      out_slope_in = out_slope_ff;
      out_used_in  = out_used_ff;
      out_degen_in = out_degen_ff;
      pop          = 1'b0;
      sq_sum       = '0;
      sx_sum       = '0;
      sy_sum       = '0;
      mag          = '0;

      unique case (state_ff)
         // count one item or open a new window
         ST_ITEM: begin
            if (head_valid) begin
               if (count_it && (head.win > open_ff)) begin
                  final_in = 1'b0;
                  state_in = ST_CLOSE0;
               end else begin
                  pop = 1'b1;
                  if (count_it) begin
                     if (head.ctrl) begin
                        if ((ccnt_ff == '0) || (head.pos != clast_ff)) begin
                           if (ccnt_ff != CNT_MAX) ccnt_in = ccnt_ff + 1'b1;
                           clast_in = head.pos;
                        end
                     end else begin
                        if ((scnt_ff == '0) || (head.pos != slast_ff)) begin
                           if (scnt_ff != CNT_MAX) scnt_in = scnt_ff + 1'b1;
                           slast_in = head.pos;
                        end
                     end
                  end
                  if (head.last) begin
                     final_in = 1'b1;
                     state_in = ST_CLOSE0;
                  end
               end
            end
         end
         // window close: x*x in flight
         ST_CLOSE0: begin
            state_in = ST_CLOSE1;
         end
         // accumulate x*x, x*y in flight
         ST_CLOSE1: begin
            if (both_nz) begin
               sq_sum = {1'b0, sxx_ff} + {1'b0, prod_ff[47:0]};
               sxx_in = sq_sum[48] ? SQ_MAX : sq_sum[47:0];
            end
            state_in = ST_CLOSE2;
         end
         // accumulate x*y, x, y and window count
         ST_CLOSE2: begin
            if (both_nz) begin
               sq_sum = {1'b0, sxy_ff} + {1'b0, prod_ff[47:0]};
               sxy_in = sq_sum[48] ? SQ_MAX : sq_sum[47:0];
               sx_sum = {1'b0, sx_ff} + 33'(ccnt_ff);
               sx_in  = sx_sum[32] ? SUM_MAX : sx_sum[31:0];
               sy_sum = {1'b0, sy_ff} + 33'(scnt_ff);
               sy_in  = sy_sum[32] ? SUM_MAX : sy_sum[31:0];
               if (used_ff != USED_MAX) used_in = used_ff + 1'b1;
            end
            scnt_in = '0;
            ccnt_in = '0;
            if (final_ff) begin
               step_in  = '0;
               state_in = ST_PROD;
            end else begin
               open_in  = head.win;
               state_in = ST_ITEM;
            end
         end
         // products of numerator and denominator, one per cycle
         ST_PROD: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd1: num_a_in = prod_ff;
               3'd2: num_a_in = num_a_ff + (prod_ff << HALF_W);
               3'd3: num_b_in = prod_ff;
               3'd4: den_a_in = prod_ff;
               3'd5: den_a_in = den_a_ff + (prod_ff << HALF_W);
               3'd6: begin
                  den_b_in = prod_ff;
                  state_in = ST_DIFF;
               end
               default: begin
               end
            endcase
         end
         // signed differences and the degenerate check
         ST_DIFF: begin
            neg_in = (num_a_ff < num_b_ff);
            dvd_in = (num_a_ff < num_b_ff) ? (num_b_ff - num_a_ff) : (num_a_ff - num_b_ff);
            den_in = den_a_ff - den_b_ff;
            rem_in = '0;
            q_in   = '0;
            ovf_in = 1'b0;
            cnt_in = '0;
            if ((den_a_ff <= den_b_ff)) begin
               res_slope_in = '0;
               res_degen_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         // restoring division, one quotient bit per cycle
         ST_DIV: begin
            if (rem_diff[64]) begin
               rem_in = rem_sh[63:0];
               q_in   = {q_ff[46:0], 1'b0};
            end else begin
               rem_in = rem_diff[63:0];
               q_in   = {q_ff[46:0], 1'b1};
            end
            ovf_in = ovf_ff | q_ff[47];
            dvd_in = {dvd_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = ST_FIN;
         end
         // round, saturate and apply the sign
         ST_FIN: begin
            if (neg_ff) begin
               mag = (big || (m49 > NEG_LIM)) ? NEG_LIM : m49;
               res_slope_in = wcrs_pkg::SLOPE_W'(~mag + 49'd1);
            end else begin
               mag = (big || (m49 > POS_LIM)) ? POS_LIM : m49;
               res_slope_in = wcrs_pkg::SLOPE_W'(mag);
            end
            res_degen_in = 1'b0;
            state_in     = ST_OUT;
         end
         // hand over the result and clear the run
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_slope_in = res_slope_ff;
               out_used_in  = used_ff;
               out_degen_in = res_degen_ff;
               open_in      = '0;
               scnt_in      = '0;
               ccnt_in      = '0;
               sx_in        = '0;
               sy_in        = '0;
               sxx_in       = '0;
               sxy_in       = '0;
               used_in      = '0;
               state_in     = ST_ITEM;
            end
         end
         default: begin
            state_in = ST_ITEM;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ITEM;
         final_ff     <= 1'b0;
         open_ff      <= '0;
         scnt_ff      <= '0;
         ccnt_ff      <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         used_ff      <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         final_ff     <= final_in;
         open_ff      <= open_in;
         scnt_ff      <= scnt_in;
         ccnt_ff      <= ccnt_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         used_ff      <= used_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      slast_ff     <= slast_in;
      clast_ff     <= clast_in;
      prod_ff      <= prod_in;
      num_a_ff     <= num_a_in;
      num_b_ff     <= num_b_in;
      den_a_ff     <= den_a_in;
      den_b_ff     <= den_b_in;
      den_ff       <= den_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      ovf_ff       <= ovf_in;
      neg_ff       <= neg_in;
      res_slope_ff <= res_slope_in;
      res_degen_ff <= res_degen_in;
      out_slope_ff <= out_slope_in;
      out_used_ff  <= out_used_in;
      out_degen_ff <= out_degen_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slope_q16    = out_slope_ff;
   assign rsp_windows_used = out_used_ff;
   assign rsp_degenerate   = out_degen_ff;

endmodule

[rtl/windowed_count_regression_slope_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_count_regression_slope_unit
// Least-squares slope of per-window distinct read counts, sample on control.
// ----------------------------------------------------------------------------
//  channel | ports  | carries
//  --------+--------+------------------------------------------------------
//  request | req_*  | position, source, last flag
//  result  | rsp_*  | slope_q16, windows_used, degenerate (one per last item)
//  config  | csr_*  | region length in megabases
//
//  the front takes one item per cycle into a four-entry queue unless the queue is full
//  the back counts items in its item state and closes a window in close0 to close2
//  a last item reaches the result port through queue and count, close, the
//  products, divide set-up, 80 divide steps, round and hand over; the close
//  runs twice when the last item opens a new window
//  reset is synchronous; region comes up at 250 megabases, all sums clear
//  a stalled result holds in the output register while items keep queueing
// ----------------------------------------------------------------------------
module windowed_count_regression_slope_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wcrs_pkg::POS_W-1:0]          req_position,
   input  logic                                req_source,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [wcrs_pkg::SLOPE_W-1:0] rsp_slope_q16,
   output logic [wcrs_pkg::USED_W-1:0]         rsp_windows_used,
   output logic                                rsp_degenerate,
   input  logic                                csr_wr_en,
   input  logic [wcrs_pkg::REGION_W-1:0]       csr_wr_data
);

   logic                push, full, pop, head_valid;
   wcrs_pkg::entry_type push_entry, head;

   // classifier
   wcrs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_position (req_position),
      .req_source   (req_source),
      .req_last     (req_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .push         (push),
      .push_entry   (push_entry),
      .full         (full)
   );

   // item queue
   wcrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // accumulator and slope
   wcrs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slope_q16    (rsp_slope_q16),
      .rsp_windows_used (rsp_windows_used),
      .rsp_degenerate   (rsp_degenerate)
   );

endmodule
